>>> rtl/double_ended_queue_macros.svh
// ----------------------------------------------------------------------------
// double_ended_queue_macros
// Assertion macros for the deque; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define DQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("deque assertion failed");
// checked on every edge, reset included
`define DQ_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("deque assertion failed");
`else
`define DQ_ASSERT(lbl, prop)
`define DQ_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

    localparam int FUNC_W = 3;
    localparam int WORD_W = 64;
    localparam int ERR_W  = 2;
    // func and value packed, padded to whole bytes
    localparam int IN_W   = ((FUNC_W + WORD_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD_FRONT = 3'd0,
        FN_ADD_BACK  = 3'd1,
        FN_REM_FRONT = 3'd2,
        FN_REM_BACK  = 3'd3,
        FN_REVERSE   = 3'd4,
        FN_STATUS    = 3'd5
    } dq_func_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } dq_err_t;

    // status of the transaction waiting on the RAM read
    typedef struct packed {
        logic    valid;
        logic    rev;
        dq_err_t err;
        logic    byp_head;   // head read hits this transaction's write
        logic    byp_tail;   // tail read hits this transaction's write
    } dq_stat_t;

endpackage

`default_nettype wire

>>> rtl/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_a,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-before-write on an address collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

>>> rtl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Ring pointer, count and direction flag; issues the store write and the
// reads of the new head and tail slots.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_ended_queue_macros.svh"

module dq_ctrl import dq_pkg::*; #(
    parameter int CAPACITY = 16,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire logic              in_vld,
    input  wire logic [FUNC_W-1:0] func,
    input  wire logic [WORD_W-1:0] value,
    output logic                   ram_we,
    output logic      [AW-1:0]     ram_waddr,
    output logic      [WORD_W-1:0] ram_wdata,
    output logic      [AW-1:0]     rd_head_addr,
    output logic      [AW-1:0]     rd_tail_addr,
    output dq_stat_t               stat,
    output logic      [WORD_W-1:0] wdata_q,
    output logic      [CW-1:0]     cnt
);

    localparam logic [AW:0]   CAP_X = (AW + 1)'(CAPACITY);
    localparam logic [AW-1:0] LAST  = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              rev_reg, rev_next;
    logic              vld2_reg;
    dq_err_t           err_reg, err_c;
    logic              byp_head_reg, byp_tail_reg;
    logic [WORD_W-1:0] wdata_reg;

    logic          fire, we_c, full, empty;
    logic [AW-1:0] waddr_c;
    logic [CW-1:0] tail_off;

    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + (AW + 1)'(off);
        if (s >= CAP_X) begin
            s = s - CAP_X;
        end
        return s[AW-1:0];
    endfunction

    assign fire  = adv & in_vld;
    assign full  = (cnt_reg == CAP_C);
    assign empty = (cnt_reg == '0);

    always_comb begin
        head_next = head_reg;
        cnt_next  = cnt_reg;
        rev_next  = rev_reg;
        err_c     = ERR_OK;
        we_c      = 1'b0;
        waddr_c   = head_reg;
        unique case (func)
            FN_ADD_FRONT, FN_ADD_BACK: begin
                if (full) begin
                    err_c = ERR_FULL;
                end else begin
                    we_c = 1'b1;
                    if ((func == FN_ADD_FRONT) != rev_reg) begin
                        head_next = (head_reg == '0) ? LAST : head_reg - 1'b1;
                        waddr_c   = head_next;
                    end else begin
                        waddr_c = slot_add(head_reg, cnt_reg);
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            FN_REM_FRONT, FN_REM_BACK: begin
                if (empty) begin
                    err_c = ERR_EMPTY;
                end else begin
                    if ((func == FN_REM_FRONT) != rev_reg) begin
                        head_next = (head_reg == LAST) ? '0 : head_reg + 1'b1;
                    end
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            FN_REVERSE: begin
                rev_next = ~rev_reg;
            end
            default: begin
                // status and unused codes change nothing
            end
        endcase
    end

    // reads follow the state as it stands after this transaction
    assign tail_off     = (cnt_next == '0) ? '0 : cnt_next - 1'b1;
    assign rd_head_addr = head_next;
    assign rd_tail_addr = slot_add(head_next, tail_off);

    assign ram_we    = fire & we_c;
    assign ram_waddr = waddr_c;
    assign ram_wdata = value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            cnt_reg  <= '0;
            rev_reg  <= 1'b0;
            vld2_reg <= 1'b0;
        end else begin
            if (fire) begin
                head_reg <= head_next;
                cnt_reg  <= cnt_next;
                rev_reg  <= rev_next;
            end
            if (adv) begin
                vld2_reg <= in_vld;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            err_reg      <= err_c;
            byp_head_reg <= ram_we & (waddr_c == rd_head_addr);
            byp_tail_reg <= ram_we & (waddr_c == rd_tail_addr);
            wdata_reg    <= value;
        end
    end

    assign stat = '{valid:    vld2_reg,
                    rev:      rev_reg,
                    err:      err_reg,
                    byp_head: byp_head_reg,
                    byp_tail: byp_tail_reg};
    assign wdata_q = wdata_reg;
    assign cnt     = cnt_reg;

    `DQ_ASSERT_ALWAYS(a_cnt_bound, !aresetn || cnt_reg <= CAP_C)
    `DQ_ASSERT(a_full_err_cnt, vld2_reg && err_reg == ERR_FULL |-> cnt_reg == CAP_C)
    `DQ_ASSERT(a_empty_err_cnt, vld2_reg && err_reg == ERR_EMPTY |-> cnt_reg == '0)
    `DQ_ASSERT(a_state_hold, $past(aresetn) && !$past(fire) |-> $stable(cnt_reg) && $stable(head_reg))

endmodule

`default_nettype wire

>>> rtl/dq_out.sv
// ----------------------------------------------------------------------------
// dq_out
// Selects head and tail words (RAM or bypass), maps them to front and back,
// and holds the result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_out import dq_pkg::*; #(
    parameter int CAPACITY = 16,
    localparam int CW      = $clog2(CAPACITY + 1),
    localparam int OUT_B   = 2 * WORD_W + CW + 2 + ERR_W,
    localparam int OUT_W   = ((OUT_B + 7) / 8) * 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dq_stat_t          stat,
    input  wire logic [CW-1:0]     cnt,
    input  wire logic [WORD_W-1:0] rd_head,
    input  wire logic [WORD_W-1:0] rd_tail,
    input  wire logic [WORD_W-1:0] wdata_q,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic      [OUT_W-1:0]  m_tdata,
    output logic                   adv
);

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [WORD_W-1:0] head_w, tail_w, front_w, back_w;
    logic              empty, full;

    assign adv = ~m_tvalid_reg | m_tready;

    assign head_w  = stat.byp_head ? wdata_q : rd_head;
    assign tail_w  = stat.byp_tail ? wdata_q : rd_tail;
    assign empty   = (cnt == '0);
    assign full    = (cnt == CAP_C);
    assign front_w = empty ? '0 : (stat.rev ? tail_w : head_w);
    assign back_w  = empty ? '0 : (stat.rev ? head_w : tail_w);

    assign m_tdata_next = OUT_W'({stat.err, full, empty, cnt, back_w, front_w});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= stat.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> rtl/double_ended_queue.sv
// Path from the accepting edge of an input transaction to result valid: input
//   register, store read register, output register. Throughput: one
//   transaction per cycle unless the output stalls; the store has one
//   write and two read ports, so head and tail are fetched in the same cycle.
// Reset clears head pointer, count, direction flag and all valid bits;
//   store contents are not cleared and are only read once written.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of 64-bit words in a ring with head, count and reverse flag.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue import dq_pkg::*; #(
    parameter int CAPACITY = 16,
    localparam int AW      = $clog2(CAPACITY),
    localparam int CW      = $clog2(CAPACITY + 1),
    localparam int OUT_B   = 2 * WORD_W + CW + 2 + ERR_W,
    localparam int OUT_W   = ((OUT_B + 7) / 8) * 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // func, value, zero pad
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [OUT_W-1:0] m_tdata    // front_value, back_value,
                                             // entry_total, is_empty,
                                             // is_full, error_code, zero pad
);

    logic              in_vld_reg;
    logic [FUNC_W-1:0] func_reg;
    logic [WORD_W-1:0] value_reg;
    logic              adv;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, rd_head_addr, rd_tail_addr;
    logic [WORD_W-1:0] ram_wdata, rd_head, rd_tail, wdata_q;
    dq_stat_t          stat;
    logic [CW-1:0]     cnt;

    assign s_tready = adv | ~in_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            func_reg  <= s_tdata[FUNC_W-1:0];
            value_reg <= s_tdata[FUNC_W +: WORD_W];
        end
    end

    dq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .in_vld       (in_vld_reg),
        .func         (func_reg),
        .value        (value_reg),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .rd_head_addr (rd_head_addr),
        .rd_tail_addr (rd_tail_addr),
        .stat         (stat),
        .wdata_q      (wdata_q),
        .cnt          (cnt)
    );

    dq_ram #(.WIDTH(WORD_W), .DEPTH(CAPACITY)) u_store (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (adv),
        .raddr_a (rd_head_addr),
        .raddr_b (rd_tail_addr),
        .rdata_a (rd_head),
        .rdata_b (rd_tail)
    );

    dq_out #(.CAPACITY(CAPACITY)) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stat     (stat),
        .cnt      (cnt),
        .rd_head  (rd_head),
        .rd_tail  (rd_tail),
        .wdata_q  (wdata_q),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .adv      (adv)
    );

endmodule

`default_nettype wire

>>> test/double_ended_queue_checker.sv
// ----------------------------------------------------------------------------
// double_ended_queue_checker
// Watches both stream channels of the deque. Every accepted input transaction
// is run through a local ring model. The predicted status is queued and then
// compared field by field with the next result transaction.
// ----------------------------------------------------------------------------
module double_ended_queue_checker import dq_pkg::*; #(
    parameter int CAPACITY = 16,
    parameter int OUT_W    = 144
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // func, value, zero pad
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,   // front_value, back_value, entry_total,
                                        // is_empty, is_full, error_code, zero pad
    output int               fail_count,
    output int               outstanding,
    output int               results_seen,
    output int               full_rejects,
    output int               empty_rejects
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // packed from the top down, so the first field lands in the highest bits
    typedef struct packed {
        dq_err_t           error_code;
        logic              is_full;
        logic              is_empty;
        logic [CW-1:0]     entry_total;
        logic [WORD_W-1:0] back_value;
        logic [WORD_W-1:0] front_value;
    } deque_status_t;

    logic [WORD_W-1:0] ring_words [CAPACITY];
    logic [AW-1:0]     head_slot;
    logic [CW-1:0]     fill;
    logic              flipped;
    deque_status_t     predicted_status [$];
    deque_status_t     want;
    deque_status_t     seen;
    int                mismatches;

    assign fail_count = mismatches;

    // Ring slots wrap through the AW-bit index; CAPACITY is a power of two.
    function automatic deque_status_t apply_op(logic [FUNC_W-1:0] fn,
                                               logic [WORD_W-1:0] word);
        deque_status_t res;
        logic          at_head;
        logic [AW-1:0] tail_slot;
        res = '0;
        res.error_code = ERR_OK;
        case (fn)
            FN_ADD_FRONT, FN_ADD_BACK: begin
                if (fill == CW'(CAPACITY)) begin
                    res.error_code = ERR_FULL;
                end else begin
                    at_head = (fn == FN_ADD_FRONT) ^ flipped;
                    if (at_head) begin
                        head_slot = head_slot - 1'b1;
                        ring_words[head_slot] = word;
                    end else begin
                        ring_words[head_slot + AW'(fill)] = word;
                    end
                    fill = fill + 1'b1;
                end
            end
            FN_REM_FRONT, FN_REM_BACK: begin
                if (fill == '0) begin
                    res.error_code = ERR_EMPTY;
                end else begin
                    at_head = (fn == FN_REM_FRONT) ^ flipped;
                    if (at_head) head_slot = head_slot + 1'b1;
                    fill = fill - 1'b1;
                end
            end
            FN_REVERSE: flipped = !flipped;
            default: ;  // status and unused codes leave the state alone
        endcase
        if (fill != '0) begin
            tail_slot = head_slot + AW'(fill - 1'b1);
            res.front_value = flipped ? ring_words[tail_slot] : ring_words[head_slot];
            res.back_value  = flipped ? ring_words[head_slot] : ring_words[tail_slot];
        end
        res.entry_total = fill;
        res.is_empty    = (fill == '0);
        res.is_full     = (fill == CW'(CAPACITY));
        return res;
    endfunction

    function automatic void check_field(string name, logic [WORD_W-1:0] exp_val,
                                        logic [WORD_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    initial begin
        mismatches = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            head_slot <= '0;
            fill      <= '0;
            flipped   <= 1'b0;
            predicted_status.delete();
            outstanding   <= 0;
            results_seen  <= 0;
            full_rejects  <= 0;
            empty_rejects <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen = m_tdata[$bits(deque_status_t)-1:0];
                if (predicted_status.size() == 0) begin
                    $error("result transaction with no operation pending");
                    mismatches++;
                end else begin
                    want = predicted_status.pop_front();
                    check_field("front_value", want.front_value, seen.front_value);
                    check_field("back_value",  want.back_value,  seen.back_value);
                    check_field("entry_total", WORD_W'(want.entry_total),
                                WORD_W'(seen.entry_total));
                    check_field("is_empty",    WORD_W'(want.is_empty), WORD_W'(seen.is_empty));
                    check_field("is_full",     WORD_W'(want.is_full),  WORD_W'(seen.is_full));
                    check_field("error_code",  WORD_W'(want.error_code),
                                WORD_W'(seen.error_code));
                end
                results_seen <= results_seen + 1;
            end
            if (s_tvalid && s_tready) begin
                want = apply_op(s_tdata[FUNC_W-1:0], s_tdata[FUNC_W +: WORD_W]);
                if (want.error_code == ERR_FULL)  full_rejects  <= full_rejects + 1;
                if (want.error_code == ERR_EMPTY) empty_rejects <= empty_rejects + 1;
                predicted_status.push_back(want);
            end
            outstanding <= predicted_status.size();
        end
    end

endmodule

>>> test/double_ended_queue_test.sv
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Drives deque operations into the block: a directed opening (empty and full
// edges, reversal, unused codes), then random fill and drain phases. Both
// channels idle at random, and the output is held off once for a long stretch.
// ----------------------------------------------------------------------------
module double_ended_queue_test import dq_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = 16;
    localparam int OUT_W       = ((2 * WORD_W + $clog2(CAPACITY + 1) + 2 + ERR_W + 7) / 8) * 8;
    localparam int RANDOM_OPS  = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_OFF    = 64;

    // codes outside the enum; the block treats them as status
    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    int fail_count, outstanding, results_seen, full_rejects, empty_rejects;
    int cycle_count = 0;
    int adds_sent = 0, removes_sent = 0, others_sent = 0;
    bit steady_sender = 1'b0;

    always #10 aclk = ~aclk;

    double_ended_queue #(.CAPACITY(CAPACITY)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    double_ended_queue_checker #(.CAPACITY(CAPACITY), .OUT_W(OUT_W)) u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .full_rejects  (full_rejects),
        .empty_rejects (empty_rejects)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_sender || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Returns at the edge where the transaction is taken.
    task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [WORD_W-1:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({word, fn});
        do @(posedge aclk); while (!s_tready);
        case (fn)
            FN_ADD_FRONT, FN_ADD_BACK: adds_sent++;
            FN_REM_FRONT, FN_REM_BACK: removes_sent++;
            default:                   others_sent++;
        endcase
    endtask

    // mode 0 fills, 1 drains, 2 balanced
    function automatic logic [FUNC_W-1:0] pick_func(int mode);
        int r, add_pct, rem_pct;
        r = $urandom_range(0, 99);
        add_pct = (mode == 0) ? 60 : (mode == 1) ? 20 : 40;
        rem_pct = 80;
        if (r < add_pct) return $urandom_range(0, 1) ? FN_ADD_BACK : FN_ADD_FRONT;
        if (r < rem_pct) return $urandom_range(0, 1) ? FN_REM_BACK : FN_REM_FRONT;
        if (r < 88) return FN_REVERSE;
        if (r < 96) return FN_STATUS;
        return $urandom_range(0, 1) ? FN_SPARE_HI : FN_SPARE_LO;
    endfunction

    // receiver side
    initial begin
        bit held_off;
        int r, window;
        held_off = 1'b0;
        window   = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (window == 0) window = $urandom_range(30, 120);
            if (!held_off && results_seen >= 40) begin
                // long stall while the sender keeps going; block has to back up
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge aclk);
                window = 0;
            end else begin
                r = $urandom_range(0, 99);
                if (window % 3 == 0 || r < 60) begin
                    m_tready <= 1'b1;
                    @(posedge aclk);
                    window--;
                end else if (r < 92) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                    window = (window > 3) ? window - 3 : 0;
                end else begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(8, 25)) @(posedge aclk);
                    window = 0;
                end
            end
        end
    end

    // sender side and verdict
    initial begin
        int mode, phase_left;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty queue edges, reversal, unused codes
        send_op(FN_STATUS, '0);
        send_op(FN_REM_FRONT, pick_word());
        send_op(FN_REM_BACK, pick_word());
        send_op(FN_REVERSE, pick_word());
        send_op(FN_SPARE_LO, pick_word());
        send_op(FN_SPARE_HI, '1);
        send_op(FN_ADD_FRONT, '1);
        send_op(FN_ADD_BACK, '0);
        send_op(FN_REVERSE, '0);
        send_op(FN_REM_BACK, '0);
        // fill to capacity, then push against the full queue
        for (int i = 0; i < CAPACITY - 1; i++)
            send_op(i[0] ? FN_ADD_BACK : FN_ADD_FRONT, pick_word());
        send_op(FN_ADD_FRONT, pick_word());
        send_op(FN_ADD_BACK, pick_word());
        send_op(FN_REM_FRONT, '0);

        mode = 1;
        phase_left = 0;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (phase_left == 0) begin
                mode = (mode + 1 + $urandom_range(0, 1)) % 3;
                phase_left = $urandom_range(20, 50);
                steady_sender = ($urandom_range(0, 3) == 0);
            end
            phase_left--;
            send_op(pick_func(mode), pick_word());
        end
        s_tvalid <= 1'b0;

        // the pending count of the last transaction shows only once outstanding is registered
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("operations: %0d adds, %0d removes, %0d reverse/status/unused; %0d results",
                 adds_sent, removes_sent, others_sent, results_seen);
        $display("refused: %0d adds at full, %0d removes at empty",
                 full_rejects, empty_rejects);
        if (fail_count == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
